// ===== rtl/plob_pkg.sv =====
// ============================================================================
// plob_pkg: shared types and constants
// Command and side codes, request and row structs, and the cell
// operation codes used by the price-level book.
// ============================================================================
package plob_pkg;

    localparam int MAX_LEVELS_DEF = 64;
    localparam int OUT_LEVELS_DEF = 10;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_CANCEL = 3'd1;
    localparam logic [2:0] CMD_TRADE  = 3'd2;
    localparam logic [2:0] CMD_FILL   = 3'd3;

    localparam logic [1:0] SIDE_BID = 2'd0;
    localparam logic [1:0] SIDE_ASK = 2'd1;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [31:0] SIZE_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  side;
        logic [31:0] price;
        logic [31:0] quantity;
    } plob_req_t;

    typedef struct packed {
        logic [3:0]  level;
        logic        bid_valid;
        logic [31:0] bid_price;
        logic [31:0] bid_size;
        logic [15:0] bid_count;
        logic        ask_valid;
        logic [31:0] ask_price;
        logic [31:0] ask_size;
        logic [15:0] ask_count;
        logic        last_row;
    } plob_row_t;

    // Content of one price level as it travels between cells.
    typedef struct packed {
        logic        valid;
        logic [31:0] price;
        logic [31:0] size;
        logic [15:0] count;
    } plob_lvl_t;

    // Operation broadcast to every cell of one side for one cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_BUMP,
        OP_INSERT,
        OP_DEC,
        OP_REMOVE
    } plob_op_e;

    typedef struct packed {
        plob_op_e    op;
        logic        desc;
        logic [31:0] price;
        logic [31:0] quantity;
    } plob_cmd_t;

endpackage

// ===== rtl/price_level_order_book_top10.sv =====
// ============================================================================
// price_level_order_book_top10: two-sided price-level book, top rows
// Sorted bid and ask level rows built from cells, with a pending-trade
// controller and a snapshot sequencer.
// ============================================================================
// A request is taken when start is high and busy is low. The request is
// registered, then decoded and applied to the level cells in the same cycle; a
// request that changes the book then streams OUT_LEVELS snapshot rows, one per
// cycle, best level first, each marked by out_valid, with last_row on the
// final one. The receiver cannot stall, so rows must be taken as they come.
// The row of cells shifts a whole side in parallel on insert or remove, so the
// side depth sets area, not rate.
module price_level_order_book_top10
    import plob_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int OUT_LEVELS = OUT_LEVELS_DEF,
    localparam int RW = (OUT_LEVELS > 1) ? $clog2(OUT_LEVELS) : 1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  plob_req_t request,
    output logic      busy,
    output logic      out_valid,
    output plob_row_t result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_EMIT
    } state_t;

    state_t      state_reg, state_next;
    plob_req_t   req_reg, req_next;
    logic        pend_reg, pend_next;
    logic [1:0]  pside_reg, pside_next;
    logic [31:0] pprice_reg, pprice_next;
    logic [RW-1:0] row_reg, row_next;
    logic        ovalid_reg, ovalid_next;
    plob_row_t   out_reg, out_next;

    plob_cmd_t bid_cmd, ask_cmd;
    plob_lvl_t bid_rd, ask_rd;
    logic      bid_hit, ask_hit, bid_one, ask_one, bid_full, ask_full;

    // Effective operation for the latched request.
    logic       eff_act, eff_add;
    logic [1:0] eff_side;
    logic [31:0] eff_price;
    logic       side_hit, side_one, side_full, changes;
    plob_op_e   op;

    always_comb
    begin
        eff_act   = 1'b0;
        eff_add   = 1'b0;
        eff_side  = req_reg.side;
        eff_price = req_reg.price;
        if (pend_reg && req_reg.command == CMD_CANCEL)
        begin
            eff_act   = (pside_reg == SIDE_BID) || (pside_reg == SIDE_ASK);
            eff_side  = (pside_reg == SIDE_ASK) ? SIDE_BID : SIDE_ASK;
            eff_price = pprice_reg;
        end
        else if (req_reg.command == CMD_ADD)
        begin
            eff_act = 1'b1;
            eff_add = 1'b1;
        end
        else if (req_reg.command == CMD_CANCEL)
            eff_act = 1'b1;
        if (eff_side != SIDE_BID && eff_side != SIDE_ASK)
            eff_act = 1'b0;
    end

    assign side_hit  = (eff_side == SIDE_ASK) ? ask_hit : bid_hit;
    assign side_one  = (eff_side == SIDE_ASK) ? ask_one : bid_one;
    assign side_full = (eff_side == SIDE_ASK) ? ask_full : bid_full;

    always_comb
    begin
        op = OP_NONE;
        if (eff_act)
        begin
            if (eff_add)
                op = side_hit ? OP_BUMP : (side_full ? OP_NONE : OP_INSERT);
            else if (side_hit)
                op = side_one ? OP_REMOVE : OP_DEC;
        end
    end
    assign changes = (op != OP_NONE);

    always_comb
    begin
        bid_cmd = '{op: OP_NONE, desc: 1'b1, price: eff_price, quantity: req_reg.quantity};
        ask_cmd = '{op: OP_NONE, desc: 1'b0, price: eff_price, quantity: req_reg.quantity};
        if (state_reg == ST_APPLY)
        begin
            if (eff_side == SIDE_ASK)
                ask_cmd.op = op;
            else
                bid_cmd.op = op;
        end
    end

    plob_side #(.MAX_LEVELS(MAX_LEVELS), .OUT_LEVELS(OUT_LEVELS)) u_bid (
        .clk(clk), .rst_n(rst_n), .cmd(bid_cmd), .rd_idx(row_reg), .rd_lvl(bid_rd),
        .any_hit(bid_hit), .hit_last_order(bid_one), .full(bid_full)
    );
    plob_side #(.MAX_LEVELS(MAX_LEVELS), .OUT_LEVELS(OUT_LEVELS)) u_ask (
        .clk(clk), .rst_n(rst_n), .cmd(ask_cmd), .rd_idx(row_reg), .rd_lvl(ask_rd),
        .any_hit(ask_hit), .hit_last_order(ask_one), .full(ask_full)
    );

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        pend_next   = pend_reg;
        pside_next  = pside_reg;
        pprice_next = pprice_reg;
        row_next    = row_reg;
        ovalid_next = 1'b0;
        out_next    = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
                row_next   = '0;
                if (pend_reg && req_reg.command == CMD_CANCEL)
                    pend_next = 1'b0;
                else if (!pend_reg || req_reg.command != CMD_FILL)
                begin
                    if (req_reg.command == CMD_TRADE)
                    begin
                        pend_next   = 1'b1;
                        pside_next  = req_reg.side;
                        pprice_next = req_reg.price;
                    end
                end
                if (changes)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                ovalid_next        = 1'b1;
                out_next.level     = 4'(row_reg);
                out_next.bid_valid = bid_rd.valid;
                out_next.bid_price = bid_rd.valid ? bid_rd.price : '0;
                out_next.bid_size  = bid_rd.valid ? bid_rd.size : '0;
                out_next.bid_count = bid_rd.valid ? bid_rd.count : '0;
                out_next.ask_valid = ask_rd.valid;
                out_next.ask_price = ask_rd.valid ? ask_rd.price : '0;
                out_next.ask_size  = ask_rd.valid ? ask_rd.size : '0;
                out_next.ask_count = ask_rd.valid ? ask_rd.count : '0;
                out_next.last_row  = (row_reg == RW'(OUT_LEVELS - 1));
                if (row_reg == RW'(OUT_LEVELS - 1))
                    state_next = ST_IDLE;
                else
                    row_next = row_reg + RW'(1);
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            req_reg    <= '0;
            pend_reg   <= 1'b0;
            pside_reg  <= '0;
            pprice_reg <= '0;
            row_reg    <= '0;
            ovalid_reg <= 1'b0;
            out_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            req_reg    <= req_next;
            pend_reg   <= pend_next;
            pside_reg  <= pside_next;
            pprice_reg <= pprice_next;
            row_reg    <= row_next;
            ovalid_reg <= ovalid_next;
            out_reg    <= out_next;
        end
    end

    // A new request may be taken in the same cycle as the last emitted row is shown.
    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;
    assign result    = out_reg;

`ifndef ASSERT_OFF
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result.last_row |=> !out_valid)
        else $error("row stream continued after last row");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg == ST_APPLY)
        else $error("accepted request not applied");
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(bid_cmd.op != OP_NONE && ask_cmd.op != OP_NONE))
        else $error("both sides changed by one request");
    a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result.last_row |=> out_valid && result.level == $past(result.level) + 4'd1)
        else $error("snapshot rows out of order");
`endif

endmodule

// ===== rtl/plob_cell.sv =====
// ============================================================================
// plob_cell: one price level slot
// Holds one level, compares it with the broadcast price and takes part in
// insert and remove shifts with its two neighbors.
// ============================================================================
module plob_cell
    import plob_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  plob_cmd_t cmd,
    input  plob_lvl_t left_lvl,   // neighbor closer to the best level
    input  logic      left_after, // left neighbor is empty or ranks after the price
    input  plob_lvl_t right_lvl,
    input  logic      left_hit,   // some cell closer to the best level holds the price
    output plob_lvl_t lvl,
    output logic      hit,
    output logic      after,      // this level is empty or ranks after the price
    output logic      at_or_beyond_hit
);

    logic        valid_reg, valid_next;
    logic [31:0] price_reg, price_next;
    logic [31:0] size_reg, size_next;
    logic [15:0] count_reg, count_next;
    logic        better;
    logic [32:0] sum;

    assign hit    = valid_reg && (price_reg == cmd.price);
    assign better = cmd.desc ? (cmd.price > price_reg) : (cmd.price < price_reg);
    assign after  = !valid_reg || better;
    assign at_or_beyond_hit = hit || left_hit;
    assign sum    = {1'b0, size_reg} + {1'b0, cmd.quantity};

    assign lvl = '{valid: valid_reg, price: price_reg, size: size_reg, count: count_reg};

    always_comb
    begin
        valid_next = valid_reg;
        price_next = price_reg;
        size_next  = size_reg;
        count_next = count_reg;
        case (cmd.op)
            OP_BUMP:
            begin
                if (hit)
                begin
                    if (count_reg != COUNT_MAX)
                        count_next = count_reg + 16'd1;
                    size_next = sum[32] ? SIZE_MAX : sum[31:0];
                end
            end
            OP_INSERT:
            begin
                if (after && left_after)
                begin
                    valid_next = left_lvl.valid;
                    price_next = left_lvl.price;
                    size_next  = left_lvl.size;
                    count_next = left_lvl.count;
                end
                else if (after)
                begin
                    valid_next = 1'b1;
                    price_next = cmd.price;
                    size_next  = cmd.quantity;
                    count_next = 16'd1;
                end
            end
            OP_DEC:
            begin
                if (hit)
                begin
                    count_next = count_reg - 16'd1;
                    size_next  = (size_reg > cmd.quantity) ? size_reg - cmd.quantity : '0;
                end
            end
            OP_REMOVE:
            begin
                // Cells at the removed level and past it pull from the right.
                if (at_or_beyond_hit)
                begin
                    valid_next = right_lvl.valid;
                    price_next = right_lvl.price;
                    size_next  = right_lvl.size;
                    count_next = right_lvl.count;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        size_reg  <= size_next;
        count_reg <= count_next;
    end

endmodule

// ===== rtl/plob_side.sv =====
// ============================================================================
// plob_side: one sorted side of the book
// A row of level cells kept best first, with lookup summary for the
// controller and a read port that walks the top rows.
// ============================================================================
module plob_side
    import plob_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int OUT_LEVELS = OUT_LEVELS_DEF,
    localparam int RW = (OUT_LEVELS > 1) ? $clog2(OUT_LEVELS) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  plob_cmd_t     cmd,
    input  logic [RW-1:0] rd_idx,
    output plob_lvl_t     rd_lvl,
    output logic          any_hit,
    output logic          hit_last_order, // hit level holds one order or none
    output logic          full
);

    plob_lvl_t lvls [MAX_LEVELS];
    logic      hits [MAX_LEVELS];
    logic      afters [MAX_LEVELS];
    logic      beyond [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] hit_vec;
    logic [MAX_LEVELS-1:0] one_vec;

    for (genvar g = 0; g < MAX_LEVELS; g++)
    begin : g_cell
        plob_lvl_t l_lvl, r_lvl;
        logic      l_after, l_beyond;
        if (g == 0)
        begin : g_first
            assign l_lvl    = '0;
            assign l_after  = 1'b0;
            assign l_beyond = 1'b0;
        end
        else
        begin : g_mid
            assign l_lvl    = lvls[g-1];
            assign l_after  = afters[g-1];
            assign l_beyond = beyond[g-1];
        end
        if (g == MAX_LEVELS - 1)
        begin : g_last
            assign r_lvl = '0;
        end
        else
        begin : g_inner
            assign r_lvl = lvls[g+1];
        end
        plob_cell u_cell (
            .clk(clk), .rst_n(rst_n), .cmd(cmd),
            .left_lvl(l_lvl), .left_after(l_after),
            .right_lvl(r_lvl), .left_hit(l_beyond),
            .lvl(lvls[g]), .hit(hits[g]), .after(afters[g]),
            .at_or_beyond_hit(beyond[g])
        );
        assign hit_vec[g] = hits[g];
        assign one_vec[g] = hits[g] && (lvls[g].count <= 16'd1);
    end

    assign any_hit        = |hit_vec;
    assign hit_last_order = |one_vec;
    assign full           = lvls[MAX_LEVELS-1].valid;
    assign rd_lvl         = lvls[rd_idx];

endmodule

// ===== verif/plob_checker.sv =====
// ============================================================================
// plob_checker: snapshot predictor and row comparator
// Watches the request and row channels of the price-level book. It keeps its
// own bid and ask level tables, computes the snapshot rows that each accepted
// request should produce, and compares every row that comes out against them.
// ============================================================================
`timescale 1ns / 100ps

module plob_checker
    import plob_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  plob_req_t request,
    input  logic      out_valid,
    input  plob_row_t result,
    output int        mismatches,
    output int        rows_due
);

    localparam int DEPTH = MAX_LEVELS_DEF;
    localparam int ROWS  = OUT_LEVELS_DEF;

    // Index 0 holds bids (best is highest), index 1 holds asks (best is lowest).
    logic [31:0] lvl_price [2][DEPTH];
    logic [31:0] lvl_size  [2][DEPTH];
    logic [15:0] lvl_count [2][DEPTH];
    int          lvl_used  [2];

    logic        trade_held;
    logic [1:0]  held_side;
    logic [31:0] held_price;

    plob_row_t   snapshot_q[$];
    int          fail_cnt;

    assign mismatches = fail_cnt;
    assign rows_due   = snapshot_q.size();

    initial
    begin
        fail_cnt   = 0;
        lvl_used   = '{0, 0};
        trade_held = 1'b0;
        held_side  = SIDE_BID;
        held_price = '0;
    end

    function automatic bit update_level(int s, bit is_add, logic [31:0] p, logic [31:0] q);
        int        n;
        int        pos;
        int        i;
        bit        found;
        bit        desc;
        logic [32:0] sum;
        n     = lvl_used[s];
        pos   = n;
        found = 0;
        desc  = (s == 0);
        for (i = 0; i < n; i++)
        begin
            if (lvl_price[s][i] == p)
            begin
                pos   = i;
                found = 1;
                break;
            end
            if (desc ? (p > lvl_price[s][i]) : (p < lvl_price[s][i]))
            begin
                pos = i;
                break;
            end
        end
        if (is_add)
        begin
            if (found)
            begin
                if (lvl_count[s][pos] != COUNT_MAX)
                    lvl_count[s][pos] = lvl_count[s][pos] + 16'd1;
                sum = {1'b0, lvl_size[s][pos]} + {1'b0, q};
                lvl_size[s][pos] = sum[32] ? SIZE_MAX : sum[31:0];
                return 1;
            end
            if (n >= DEPTH)
                return 0;
            for (i = n; i > pos; i--)
            begin
                lvl_price[s][i] = lvl_price[s][i-1];
                lvl_size[s][i]  = lvl_size[s][i-1];
                lvl_count[s][i] = lvl_count[s][i-1];
            end
            lvl_price[s][pos] = p;
            lvl_size[s][pos]  = q;
            lvl_count[s][pos] = 16'd1;
            lvl_used[s]       = n + 1;
            return 1;
        end
        if (!found)
            return 0;
        if (lvl_count[s][pos] <= 16'd1)
        begin
            for (i = pos; i + 1 < n; i++)
            begin
                lvl_price[s][i] = lvl_price[s][i+1];
                lvl_size[s][i]  = lvl_size[s][i+1];
                lvl_count[s][i] = lvl_count[s][i+1];
            end
            lvl_used[s] = n - 1;
        end
        else
        begin
            lvl_count[s][pos] = lvl_count[s][pos] - 16'd1;
            lvl_size[s][pos]  = (lvl_size[s][pos] > q) ? lvl_size[s][pos] - q : '0;
        end
        return 1;
    endfunction

    function automatic void push_snapshot();
        plob_row_t r;
        for (int k = 0; k < ROWS; k++)
        begin
            r           = '0;
            r.level     = k[3:0];
            r.last_row  = (k == ROWS - 1);
            if (k < lvl_used[0])
            begin
                r.bid_valid = 1'b1;
                r.bid_price = lvl_price[0][k];
                r.bid_size  = lvl_size[0][k];
                r.bid_count = lvl_count[0][k];
            end
            if (k < lvl_used[1])
            begin
                r.ask_valid = 1'b1;
                r.ask_price = lvl_price[1][k];
                r.ask_size  = lvl_size[1][k];
                r.ask_count = lvl_count[1][k];
            end
            snapshot_q.insert(snapshot_q.size(), r);
        end
    endfunction

    function automatic void apply_request(plob_req_t rq);
        bit changed;
        changed = 0;
        if (trade_held && rq.command == CMD_FILL)
            return;
        if (trade_held && rq.command == CMD_CANCEL)
        begin
            // A cancel resolves the held trade against the opposite side.
            trade_held = 1'b0;
            if (held_side == SIDE_BID || held_side == SIDE_ASK)
                changed = update_level((held_side == SIDE_ASK) ? 0 : 1, 0,
                                       held_price, rq.quantity);
        end
        else if (rq.command == CMD_TRADE)
        begin
            trade_held = 1'b1;
            held_side  = rq.side;
            held_price = rq.price;
        end
        else if ((rq.command == CMD_ADD || rq.command == CMD_CANCEL) &&
                 (rq.side == SIDE_BID || rq.side == SIDE_ASK))
        begin
            changed = update_level((rq.side == SIDE_ASK) ? 1 : 0,
                                   rq.command == CMD_ADD, rq.price, rq.quantity);
        end
        if (changed)
            push_snapshot();
    endfunction

    function automatic void report(string field, logic [31:0] want, logic [31:0] got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t: row %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
    endfunction

    always @(posedge clk)
    begin
        plob_row_t want;
        if (rst_n)
        begin
            if (out_valid)
            begin
                if (snapshot_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: unexpected row, level %0d", $realtime, result.level);
                end
                else
                begin
                    want = snapshot_q.pop_front();
                    if (result.level !== want.level)
                        report("level", 32'(want.level), 32'(result.level));
                    if (result.bid_valid !== want.bid_valid)
                        report("bid_valid", 32'(want.bid_valid), 32'(result.bid_valid));
                    if (result.bid_price !== want.bid_price)
                        report("bid_price", want.bid_price, result.bid_price);
                    if (result.bid_size !== want.bid_size)
                        report("bid_size", want.bid_size, result.bid_size);
                    if (result.bid_count !== want.bid_count)
                        report("bid_count", 32'(want.bid_count), 32'(result.bid_count));
                    if (result.ask_valid !== want.ask_valid)
                        report("ask_valid", 32'(want.ask_valid), 32'(result.ask_valid));
                    if (result.ask_price !== want.ask_price)
                        report("ask_price", want.ask_price, result.ask_price);
                    if (result.ask_size !== want.ask_size)
                        report("ask_size", want.ask_size, result.ask_size);
                    if (result.ask_count !== want.ask_count)
                        report("ask_count", 32'(want.ask_count), 32'(result.ask_count));
                    if (result.last_row !== want.last_row)
                        report("last_row", 32'(want.last_row), 32'(result.last_row));
                end
            end
            if (start && !busy)
                apply_request(request);
        end
    end

endmodule

// ===== verif/tb.sv =====
// ============================================================================
// tb: price-level order book testbench
// Drives directed and random book requests with random idle bursts, while a
// checker beside the block predicts and compares every snapshot row.
// ============================================================================
`timescale 1ns / 100ps

module tb;
    import plob_pkg::*;

    localparam logic [2:0] CMD_OTHER    = 3'd4;
    localparam logic [2:0] CMD_OTHER_HI = 3'd7;
    localparam logic [1:0] SIDE_NONE    = 2'd2;
    localparam logic [1:0] SIDE_NONE_HI = 2'd3;
    localparam int         STALL_LIMIT  = 3000;

    logic      clk;
    logic      rst_n;
    logic      start;
    plob_req_t request;
    logic      busy;
    logic      out_valid;
    plob_row_t result;
    int        mismatches;
    int        rows_due;
    int        stall_cnt;
    bit        gaps_on;
    logic [31:0] pool [16];

    price_level_order_book_top10 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .out_valid (out_valid),
        .result    (result)
    );

    plob_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .out_valid  (out_valid),
        .result     (result),
        .mismatches (mismatches),
        .rows_due   (rows_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Ends the run if neither a request nor a row moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || out_valid || !rst_n)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("[price_level_order_book_top10] ERROR");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    task automatic send(logic [2:0] c, logic [1:0] s, logic [31:0] p, logic [31:0] q);
        request <= '{command: c, side: s, price: p, quantity: q};
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        while (rows_due != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_price();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return pool[$urandom_range(0, 15)];
    endfunction

    initial
    begin
        int          cnt;
        int          r;
        logic [2:0]  c;
        logic [1:0]  s;
        logic [31:0] q;
        start   = 1'b0;
        request = '0;
        rst_n   = 1'b0;
        gaps_on = 1'b1;
        for (int i = 0; i < 16; i++)
            pool[i] = (i < 8) ? 32'd1_000_000 + i * 100 : $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: price extremes, size saturation and underflow, removal.
        send(CMD_ADD, SIDE_BID, 32'h0, 32'hFFFF_FFFF);
        send(CMD_ADD, SIDE_BID, 32'hFFFF_FFFF, 32'h1);
        send(CMD_ADD, SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_ADD, SIDE_ASK, 32'h0, 32'h5);
        send(CMD_ADD, SIDE_BID, 32'h0, 32'hFFFF_FFFF);
        send(CMD_CANCEL, SIDE_BID, 32'h0, 32'h1);
        send(CMD_ADD, SIDE_ASK, 32'h0, 32'h3);
        send(CMD_CANCEL, SIDE_ASK, 32'h0, 32'hFFFF_FFFF);
        send(CMD_CANCEL, SIDE_ASK, 32'h0, 32'h0);
        send(CMD_CANCEL, SIDE_BID, 32'h1234, 32'h7);
        send(CMD_ADD, SIDE_NONE, 32'h55, 32'h1);
        send(CMD_ADD, SIDE_NONE_HI, 32'h55, 32'h1);
        send(CMD_OTHER, SIDE_BID, 32'h0, 32'h1);
        send(CMD_OTHER_HI, SIDE_ASK, 32'hFFFF_FFFF, 32'h1);
        send(CMD_FILL, SIDE_BID, 32'h0, 32'h1);
        // Held trades: fill ignored, replacement, cancel on the opposite side.
        send(CMD_TRADE, SIDE_BID, 32'h0, 32'h1);
        send(CMD_FILL, SIDE_ASK, 32'h0, 32'h1);
        send(CMD_TRADE, SIDE_ASK, 32'hFFFF_FFFF, 32'h1);
        send(CMD_ADD, SIDE_ASK, 32'h9, 32'h1);
        send(CMD_CANCEL, SIDE_ASK, 32'h9, 32'h2);
        send(CMD_TRADE, SIDE_NONE, 32'h0, 32'h1);
        send(CMD_CANCEL, SIDE_ASK, 32'hFFFF_FFFF, 32'h1);
        send(CMD_TRADE, SIDE_ASK, 32'h0, 32'h8);
        send(CMD_CANCEL, SIDE_ASK, 32'h0, 32'h8);

        // The sender holds off until every expected row is back.
        drain();

        // Fill the bid table, then offer one more new price.
        for (int i = 0; i < 65; i++)
            send(CMD_ADD, SIDE_BID, 32'd500 + i * 3, $urandom);
        for (int i = 0; i < 6; i++)
            send(CMD_CANCEL, SIDE_BID, 32'd500 + i * 3, $urandom);

        // Random requests, mostly adds and cancels on a small set of prices.
        cnt = 0;
        while (cnt < 135)
        begin
            r = $urandom_range(0, 99);
            s = (r % 10 == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
            q = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 1000));
            if (r < 40)
                c = CMD_ADD;
            else if (r < 70)
                c = CMD_CANCEL;
            else if (r < 82)
                c = CMD_TRADE;
            else if (r < 90)
                c = CMD_FILL;
            else
                c = 3'($urandom_range(4, 7));
            if (cnt >= 100)
                gaps_on = 1'b0;
            send(c, s, pick_price(), q);
            cnt++;
        end

        drain();
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("[price_level_order_book_top10] OK");
        else
            $display("[price_level_order_book_top10] ERROR");
        $finish;
    end

endmodule
